FILE: rtl/dolc_pkg.sv
package dolc_pkg;

    localparam int DEF_MAX_WORDS = 256;
    localparam int DEF_MAX_LEN   = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TEXT = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [7:0]  CHAR_A    = 8'h61;
    localparam logic [7:0]  CHAR_Z    = 8'h7A;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] ch;
        logic       word_end;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_char;
        logic [15:0] corrections;
        logic        last;
    } rsp_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CHAR_A) && (c <= CHAR_Z);
    endfunction

endpackage

FILE: rtl/dictionary_one_letter_correction.sv
// Flow: a dictionary load or a buffered letter is taken when accepted; a passed-through letter
//   goes out via ST_TAIL. A word close scans each entry (ST_SCAN_RD, ST_SCAN_LEN), comparing an
//   equal-length one by position up to a second mismatch (ST_CMP); a scan with no hit ends in
//   ST_SCAN_RD. Letters go out via ST_EMIT_RD and ST_EMIT_WR, the closing result via ST_TAIL.
// Throughput: one transaction worked at a time, set by the dictionary scan over the single
//   character read port; output stalls hold the flow. Reset: control state clears.
module dictionary_one_letter_correction #(
    parameter int MAX_WORDS = dolc_pkg::DEF_MAX_WORDS,
    parameter int MAX_LEN   = dolc_pkg::DEF_MAX_LEN
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dolc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dolc_pkg::rsp_t rsp
);

    import dolc_pkg::*;

    localparam int CW = $clog2(MAX_WORDS + 1);           // holds the entry count
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);             // holds a word length

    localparam logic [CW-1:0] WORDS_C = CW'(MAX_WORDS);
    localparam logic [LW-1:0] LEN_C   = LW'(MAX_LEN);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN_RD  = 7'b0000010,   // fetch length and first char of entry k
        ST_SCAN_LEN = 7'b0000100,   // length check
        ST_CMP      = 7'b0001000,   // one position compared per cycle
        ST_EMIT_RD  = 7'b0010000,
        ST_EMIT_WR  = 7'b0100000,
        ST_TAIL     = 7'b1000000    // closing char or count
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] dict_count_reg, dict_count_next;
    logic [LW-1:0] load_pos_reg, load_pos_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    logic          ovf_reg, ovf_next;
    logic [15:0]   corr_reg, corr_next;
    req_t          item_reg, item_next;
    logic [CW-1:0] k_reg, k_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          seen_reg, seen_next;       // one mismatch already seen in entry k
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_k_reg, hit_k_next;
    logic [LW-1:0] emit_reg, emit_next;

    logic [7:0]    wbuf_reg [MAX_LEN];
    logic          wbuf_we;
    logic [PW-1:0] wbuf_idx;
    logic [7:0]    wbuf_rd;

    // dictionary memory ports
    logic             chars_we, chars_re, lens_we, lens_re;
    logic [AW+PW-1:0] chars_waddr, chars_raddr;
    logic [AW-1:0]    lens_raddr;
    logic [LW-1:0]    lens_wdata, lens_rdata;
    logic [7:0]       chars_rdata;
    logic             load_go;
    logic [LW-1:0]    pos_inc;

    // output register
    logic ld, out_free;
    rsp_t ld_data;

    logic mism, last_pos;

    dolc_dict_mem #(
        .MAX_WORDS (MAX_WORDS),
        .MAX_LEN   (MAX_LEN)
    ) u_dict (
        .clk         (clk),
        .chars_we    (chars_we),
        .chars_waddr (chars_waddr),
        .chars_wdata (req.ch),
        .chars_re    (chars_re),
        .chars_raddr (chars_raddr),
        .chars_rdata (chars_rdata),
        .lens_we     (lens_we),
        .lens_waddr  (dict_count_reg[AW-1:0]),
        .lens_wdata  (lens_wdata),
        .lens_re     (lens_re),
        .lens_raddr  (lens_raddr),
        .lens_rdata  (lens_rdata)
    );

    dolc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld        (ld),
        .ld_data   (ld_data),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // new transactions only between items
    assign req_stall = (state_reg != ST_IDLE);

    // dictionary load path, written in the accepting cycle
    assign load_go     = (state_reg == ST_IDLE) && req_valid && (req.command == CMD_LOAD)
                         && (dict_count_reg < WORDS_C);
    assign chars_we    = load_go && (load_pos_reg < LEN_C);
    assign chars_waddr = {dict_count_reg[AW-1:0], load_pos_reg[PW-1:0]};
    assign pos_inc     = load_pos_reg + LW'(load_pos_reg < LEN_C);
    assign lens_we     = load_go && req.word_end;
    assign lens_wdata  = pos_inc;

    assign wbuf_idx = (state_reg == ST_CMP) ? pos_reg : emit_reg[PW-1:0];
    assign wbuf_rd  = wbuf_reg[wbuf_idx];

    assign mism     = (chars_rdata != wbuf_rd);
    assign last_pos = (LW'(pos_reg) == (wlen_reg - LW'(1)));

    always_comb
    begin
        state_next      = state_reg;
        dict_count_next = dict_count_reg;
        load_pos_next   = load_pos_reg;
        wlen_next       = wlen_reg;
        ovf_next        = ovf_reg;
        corr_next       = corr_reg;
        item_next       = item_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        hit_next        = hit_reg;
        hit_k_next      = hit_k_reg;
        emit_next       = emit_reg;
        wbuf_we         = 1'b0;
        chars_re        = 1'b0;
        chars_raddr     = {k_reg[AW-1:0], PW'(0)};
        lens_re         = 1'b0;
        lens_raddr      = k_reg[AW-1:0];
        ld              = 1'b0;
        ld_data         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    unique case (req.command)
                        CMD_LOAD:
                        begin
                            if (load_go)
                            begin
                                if (req.word_end)
                                begin
                                    dict_count_next = dict_count_reg + CW'(1);
                                    load_pos_next   = '0;
                                end
                                else
                                begin
                                    load_pos_next = pos_inc;
                                end
                            end
                        end
                        CMD_TEXT, CMD_END:
                        begin
                            if ((req.command == CMD_TEXT) && is_lower(req.ch))
                            begin
                                if (ovf_reg)
                                begin
                                    state_next = ST_TAIL;          // pass straight through
                                end
                                else if (wlen_reg < LEN_C)
                                begin
                                    wbuf_we   = 1'b1;
                                    wlen_next = wlen_reg + LW'(1);
                                end
                                else
                                begin
                                    // buffer full: flush uncorrected, then this letter
                                    ovf_next   = 1'b1;
                                    hit_next   = 1'b0;
                                    emit_next  = '0;
                                    state_next = ST_EMIT_RD;
                                end
                            end
                            else if (ovf_reg)
                            begin
                                ovf_next   = 1'b0;
                                state_next = ST_TAIL;
                            end
                            else
                            begin
                                k_next     = '0;
                                hit_next   = 1'b0;
                                emit_next  = '0;
                                state_next = (wlen_reg == '0) ? ST_EMIT_RD : ST_SCAN_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                if (k_reg < dict_count_reg)
                begin
                    lens_re    = 1'b1;
                    chars_re   = 1'b1;
                    state_next = ST_SCAN_LEN;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SCAN_LEN:
            begin
                if (lens_rdata == wlen_reg)
                begin
                    pos_next   = '0;
                    seen_next  = 1'b0;
                    state_next = ST_CMP;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_CMP:
            begin
                // next position fetched while this one is compared
                chars_re    = 1'b1;
                chars_raddr = {k_reg[AW-1:0], pos_reg + PW'(1)};
                if (mism && seen_reg)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
                else if (last_pos)
                begin
                    if (mism || seen_reg)
                    begin
                        hit_next   = 1'b1;
                        hit_k_next = k_reg[AW-1:0];
                        emit_next  = '0;
                        if (corr_reg != COUNT_MAX)
                        begin
                            corr_next = corr_reg + 16'd1;
                        end
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        // exact match is no correction; keep looking
                        k_next     = k_reg + CW'(1);
                        state_next = ST_SCAN_RD;
                    end
                end
                else
                begin
                    pos_next  = pos_reg + PW'(1);
                    seen_next = seen_reg || mism;
                end
            end
            ST_EMIT_RD:
            begin
                chars_raddr = {hit_k_reg, emit_reg[PW-1:0]};
                if (emit_reg == wlen_reg)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    chars_re   = hit_reg;
                    state_next = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    ld               = 1'b1;
                    ld_data.kind     = KIND_TEXT;
                    ld_data.out_char = hit_reg ? chars_rdata : wbuf_rd;
                    emit_next        = emit_reg + LW'(1);
                    state_next       = ST_EMIT_RD;
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    ld           = 1'b1;
                    ld_data.last = 1'b1;
                    if (item_reg.command == CMD_END)
                    begin
                        ld_data.kind        = KIND_COUNT;
                        ld_data.corrections = corr_reg;
                        corr_next           = '0;
                    end
                    else
                    begin
                        ld_data.kind     = KIND_TEXT;
                        ld_data.out_char = item_reg.ch;
                    end
                    wlen_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dict_count_reg <= '0;
            load_pos_reg   <= '0;
            wlen_reg       <= '0;
            ovf_reg        <= 1'b0;
            corr_reg       <= '0;
            k_reg          <= '0;
            pos_reg        <= '0;
            seen_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            emit_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            dict_count_reg <= dict_count_next;
            load_pos_reg   <= load_pos_next;
            wlen_reg       <= wlen_next;
            ovf_reg        <= ovf_next;
            corr_reg       <= corr_next;
            k_reg          <= k_next;
            pos_reg        <= pos_next;
            seen_reg       <= seen_next;
            hit_reg        <= hit_next;
            emit_reg       <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        hit_k_reg <= hit_k_next;
        if (wbuf_we)
        begin
            wbuf_reg[wlen_reg[PW-1:0]] <= req.ch;
        end
    end

    // results only go into a free output register
    assert property (@(posedge clk) disable iff (!rst_n) ld |-> out_free)
        else $error("result loaded into a busy output register");

    // word and entry bookkeeping stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (wlen_reg <= LEN_C) && (load_pos_reg <= LEN_C) && (dict_count_reg <= WORDS_C))
        else $error("length or count out of range");

    // overflow mode never leaves letters buffered between transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && ovf_reg) |-> (wlen_reg == '0))
        else $error("letters buffered while in overflow pass-through");

    // a corrected word bumps the counter unless saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CMP) && (state_next == ST_EMIT_RD) && (corr_reg != COUNT_MAX))
        |=> (corr_reg == $past(corr_reg) + 16'd1))
        else $error("correction not counted");

    // the scanned entry index never passes the loaded entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg <= dict_count_reg))
        else $error("scan index beyond dictionary");

endmodule

FILE: rtl/dolc_dict_mem.sv
module dolc_dict_mem #(
    parameter int  MAX_WORDS = 256,
    parameter int  MAX_LEN   = 16,
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
    localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int LW = $clog2(MAX_LEN + 1)
) (
    input  logic              clk,
    input  logic              chars_we,
    input  logic [AW+PW-1:0]  chars_waddr,
    input  logic [7:0]        chars_wdata,
    input  logic              chars_re,
    input  logic [AW+PW-1:0]  chars_raddr,
    output logic [7:0]        chars_rdata,
    input  logic              lens_we,
    input  logic [AW-1:0]     lens_waddr,
    input  logic [LW-1:0]     lens_wdata,
    input  logic              lens_re,
    input  logic [AW-1:0]     lens_raddr,
    output logic [LW-1:0]     lens_rdata
);

    // entry k, position t lives at {k, t}
    logic [7:0]    chars_mem [2**(AW+PW)];
    logic [LW-1:0] lens_mem  [2**AW];

    always_ff @(posedge clk)
    begin
        if (chars_we)
        begin
            chars_mem[chars_waddr] <= chars_wdata;
        end
        if (chars_re)
        begin
            chars_rdata <= chars_mem[chars_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lens_we)
        begin
            lens_mem[lens_waddr] <= lens_wdata;
        end
        if (lens_re)
        begin
            lens_rdata <= lens_mem[lens_raddr];
        end
    end

endmodule

FILE: rtl/dolc_out_stage.sv
module dolc_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ld,
    input  dolc_pkg::rsp_t ld_data,
    output logic           free,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dolc_pkg::rsp_t rsp
);

    import dolc_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        if (ld)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            data_reg <= ld_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule
